/* src/nqc_pkg.sv */
package nqc_pkg;

    // Default board limit handed to the top level
    localparam int MAX_QUEENS_DEF = 16;

    localparam int CAND_W  = 64;
    localparam int TALLY_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] BOARD_SIZE_RESET = 5'd8;

    // Long division by the board size runs one nibble per cycle
    localparam int NIB_W     = 4;
    localparam int NIB_STEPS = CAND_W / NIB_W;
    localparam int NIB_CNT_W = $clog2(NIB_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CAND_W-1:0] candidate;
        logic              restart;
        logic              single;    // one-queen board, no decode needed
    } nqc_item_t;

endpackage

/* src/nqc_front.sv */
module nqc_front import nqc_pkg::*;
#(
    parameter int MAX_QUEENS = MAX_QUEENS_DEF,
    localparam int SIZE_W = $clog2(MAX_QUEENS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CAND_W-1:0] candidate,
    input  logic              restart,
    input  logic              q_full,
    output logic              q_push,
    output nqc_item_t         q_item,
    output logic [SIZE_W-1:0] q_size
);

    logic [CFG_W-1:0]  board_size_reg;
    logic [SIZE_W-1:0] eff_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg <= BOARD_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            board_size_reg <= cfg_wdata;
        end
    end

    // Clamp the board size into 1..MAX_QUEENS
    always_comb
    begin
        if (board_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (board_size_reg > CFG_W'(MAX_QUEENS))
        begin
            eff_size = SIZE_W'(MAX_QUEENS);
        end
        else
        begin
            eff_size = SIZE_W'(board_size_reg);
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign q_item.candidate = candidate;
    assign q_item.restart   = restart;
    assign q_item.single    = (eff_size == SIZE_W'(1));
    assign q_size           = eff_size;

endmodule

/* src/nqc_queue.sv */
module nqc_queue import nqc_pkg::*;
#(
    parameter int SIZE_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nqc_item_t         push_item,
    input  logic [SIZE_W-1:0] push_size,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output nqc_item_t         pop_item,
    output logic [SIZE_W-1:0] pop_size
);

    nqc_item_t         item_mem [QUEUE_DEPTH];
    logic [SIZE_W-1:0] size_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = item_mem[rd_ptr_reg];
    assign pop_size  = size_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            size_mem[wr_ptr_reg] <= push_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/nqc_back.sv */
module nqc_back import nqc_pkg::*;
#(
    parameter int MAX_QUEENS = MAX_QUEENS_DEF,
    localparam int SIZE_W = $clog2(MAX_QUEENS + 1),
    localparam int ROW_W  = (MAX_QUEENS > 1) ? $clog2(MAX_QUEENS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  nqc_item_t          q_item,
    input  logic [SIZE_W-1:0]  q_size,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               acceptable,
    output logic [TALLY_W-1:0] solutions_so_far
);

    localparam int CMP_W = ROW_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CAND_W-1:0]    work_reg;
    logic [ROW_W-1:0]     rem_reg;
    logic [NIB_CNT_W-1:0] nib_reg;
    logic [ROW_W-1:0]     col_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic                 restart_reg;
    logic                 ok_reg;
    logic [ROW_W-1:0]     rows_reg [MAX_QUEENS];
    logic [TALLY_W-1:0]   tally_reg;
    logic                 out_valid_reg;
    logic                 acceptable_reg;
    logic [TALLY_W-1:0]   solutions_reg;

    logic [ROW_W-1:0]     rem_next;
    logic [NIB_W-1:0]     quot_nib;
    logic [CMP_W-1:0]     trial;
    logic [CMP_W-1:0]     n_ext;
    logic                 hit;
    logic [ROW_W-1:0]     rdiff;
    logic [ROW_W-1:0]     gap;
    logic                 last_col;
    logic                 last_nib;
    logic [TALLY_W-1:0]   tally_base;
    logic [TALLY_W-1:0]   tally_next;

    // One radix-16 long-division step: four restoring subtracts of the size
    always_comb
    begin
        n_ext    = CMP_W'(size_reg);
        rem_next = rem_reg;
        quot_nib = '0;
        trial    = '0;
        for (int j = NIB_W - 1; j >= 0; j--)
        begin
            trial = {rem_next, work_reg[CAND_W - NIB_W + j]};
            if (trial >= n_ext)
            begin
                rem_next    = ROW_W'(trial - n_ext);
                quot_nib[j] = 1'b1;
            end
            else
            begin
                rem_next = trial[ROW_W-1:0];
            end
        end
    end

    // Compare the new row against every earlier column
    always_comb
    begin
        hit   = 1'b0;
        rdiff = '0;
        gap   = '0;
        for (int d = 0; d < MAX_QUEENS; d++)
        begin
            if (ROW_W'(d) < col_reg)
            begin
                rdiff = (rows_reg[d] > rem_next) ? rows_reg[d] - rem_next
                                                 : rem_next - rows_reg[d];
                gap   = col_reg - ROW_W'(d);
                if (rdiff == '0 || rdiff == gap)
                begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign last_col = (col_reg == ROW_W'(size_reg - SIZE_W'(1)));
    assign last_nib = (nib_reg == NIB_CNT_W'(NIB_STEPS - 1));

    // Saturating count, cleared first on restart
    assign tally_base = restart_reg ? '0 : tally_reg;
    assign tally_next = (ok_reg && tally_base != '1) ? tally_base + 1'b1 : tally_base;

    assign q_pop            = (state_reg == ST_IDLE) && q_valid;
    assign out_valid        = out_valid_reg;
    assign acceptable       = acceptable_reg;
    assign solutions_so_far = solutions_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            work_reg       <= '0;
            rem_reg        <= '0;
            nib_reg        <= '0;
            col_reg        <= '0;
            size_reg       <= '0;
            restart_reg    <= 1'b0;
            ok_reg         <= 1'b0;
            tally_reg      <= '0;
            out_valid_reg  <= 1'b0;
            acceptable_reg <= 1'b0;
            solutions_reg  <= '0;
            for (int i = 0; i < MAX_QUEENS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        work_reg    <= q_item.candidate;
                        restart_reg <= q_item.restart;
                        size_reg    <= q_size;
                        rem_reg     <= '0;
                        nib_reg     <= '0;
                        col_reg     <= '0;
                        ok_reg      <= 1'b1;
                        state_reg   <= q_item.single ? ST_DONE : ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    work_reg <= {work_reg[CAND_W-NIB_W-1:0], quot_nib};
                    if (last_nib)
                    begin
                        // Digit complete: store the row and check it
                        rows_reg[col_reg] <= rem_next;
                        rem_reg           <= '0;
                        nib_reg           <= '0;
                        if (hit)
                        begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else if (last_col)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        nib_reg <= nib_reg + 1'b1;
                    end
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        acceptable_reg <= ok_reg;
                        solutions_reg  <= tally_next;
                        tally_reg      <= tally_next;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/n_queens_candidate_checker_core.sv */
// N-queens candidate checker.
// Input channel (in_valid / in_stall): one item carries a 64-bit placement
// index and a restart flag. The index is split into board_size base-n digits,
// lowest first; digit c is the row of the queen in column c.
// Output channel (out_valid / out_stall): one item per input item, giving
// acceptable (no shared row or diagonal) and the saturating solution count.
// Config: cfg_we writes cfg_wdata into board_size; write only while idle.
// Sizes 0 and above MAX_QUEENS act as 1 and MAX_QUEENS.
// Flow: the back end checks one item at a time, decoding columns up to
// and including the first conflicting one (at most board_size); a
// one-queen board skips decoding. The divider retires one nibble of the
// index per cycle. A two-entry queue holds up to two items waiting for
// the back end.
// Reset: clears the count, empties the queue and sets board_size to 8.
// A stalled output item holds; the back end waits in its done state and the
// queue keeps taking items until full, then in_stall rises.
module n_queens_candidate_checker_core import nqc_pkg::*;
#(
    parameter int MAX_QUEENS = MAX_QUEENS_DEF,
    localparam int SIZE_W = $clog2(MAX_QUEENS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CAND_W-1:0]  candidate,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               acceptable,
    output logic [TALLY_W-1:0] solutions_so_far
);

    logic              q_full;
    logic              q_push;
    nqc_item_t         q_push_item;
    logic [SIZE_W-1:0] q_push_size;
    logic              q_valid;
    logic              q_pop;
    nqc_item_t         q_pop_item;
    logic [SIZE_W-1:0] q_pop_size;

    // Front: hold the board size, classify and enqueue items
    nqc_front #(
        .MAX_QUEENS (MAX_QUEENS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .restart   (restart),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item),
        .q_size    (q_push_size)
    );

    // Queue: decouple intake from the long-running check
    nqc_queue #(
        .SIZE_W (SIZE_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .push_size (q_push_size),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item),
        .pop_size  (q_pop_size)
    );

    // Back: decode digits, check pairs, advance the count
    nqc_back #(
        .MAX_QUEENS (MAX_QUEENS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_pop_item),
        .q_size           (q_pop_size),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .acceptable       (acceptable),
        .solutions_so_far (solutions_so_far)
    );

endmodule

/* src/nqc_checker.sv */
module nqc_checker import nqc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               acceptable,
    input logic [TALLY_W-1:0] solutions_so_far
);

    // Queue entries plus one in the back end plus the output register
    localparam logic [7:0] MAX_PENDING = 8'(QUEUE_DEPTH + 2);

    logic [7:0] in_cnt_reg;
    logic [7:0] out_cnt_reg;
    logic [7:0] pending;

    assign pending = in_cnt_reg - out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_cnt_reg <= in_cnt_reg + 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(acceptable)
                                   && $stable(solutions_so_far))
        else $error("stalled output item changed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && acceptable |-> solutions_so_far != '0)
        else $error("acceptable item with zero count");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> pending != '0)
        else $error("output item with no input item pending");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= MAX_PENDING)
        else $error("more items in flight than storage holds");

endmodule

bind n_queens_candidate_checker_core nqc_checker u_nqc_checker (.*);
